@@ rtl/core/acr_pkg.sv @@
// Shared types, constants and handshake structs of the ARP cache responder.
package acr_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [10:0] MIN_FRAME_LEN  = 11'd28;
  localparam logic [15:0] HW_ETHER       = 16'h0001;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] OPCODE_REQUEST = 16'd1;
  localparam logic [15:0] OPCODE_REPLY   = 16'd2;
  localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_FRAME  = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_REPLY    = 3'd1,
    ACT_RESOLVED = 3'd2,
    ACT_HIT      = 3'd3,
    ACT_MISS     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    SOP_NONE    = 2'd0,
    SOP_REQUEST = 2'd1,
    SOP_REPLY   = 2'd2
  } send_op_t;

  typedef enum logic [0:0] {
    REG_OWN_IP  = 1'b0,
    REG_OWN_MAC = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    mode_t       mode;
    logic [10:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } req_t;

  typedef struct packed {
    action_t     action;
    send_op_t    send_op;
    logic [47:0] mac_out;
    logic [31:0] ip_out;
  } res_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/acr_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface acr_req_if;
  logic          valid;
  logic          ready;
  acr_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acr_res_if;
  logic          valid;
  logic          ready;
  acr_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/acr_ctrl.sv @@
// Controller state machine: accept, scan the cache, finish.
module acr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  acr_pkg::sts_t sts,
  output acr_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.finish = (state_r == S_FIN) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

@@ rtl/core/acr_dp.sv @@
// Datapath: request register, cache entries, scan results and result register.
module acr_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  acr_pkg::cmd_t                  cmd,
  output acr_pkg::sts_t                  sts,
  input  acr_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output acr_pkg::res_t                  out_data,
  input  logic                           cfg_we,
  input  acr_pkg::cfg_reg_t              cfg_idx,
  input  logic [acr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = acr_pkg::IDX_W;
  localparam int N  = acr_pkg::CACHE_ENTRIES;

  acr_pkg::req_t req_r;
  logic [31:0]   own_ip_r;
  logic [47:0]   own_mac_r;
  logic [31:0]   tick_r;

  logic          valid_r [N];
  logic [31:0]   ip_mem_r [N];
  logic [47:0]   mac_mem_r [N];
  logic [31:0]   stamp_mem_r [N];

  logic [IW-1:0] idx_r;
  logic          match_found_r, free_found_r;
  logic [IW-1:0] match_idx_r, free_idx_r, min_idx_r;
  logic [47:0]   match_mac_r;
  logic [31:0]   min_stamp_r;

  logic          out_valid_r;
  acr_pkg::res_t out_r, res_nxt;

  logic [31:0]   key;
  logic          hit, first, frame_ok, sip_nz, learn_en;
  logic [IW-1:0] slot;

  assign key   = (req_r.mode == acr_pkg::MODE_LOOKUP) ? req_r.query_ip : req_r.sender_ip;
  assign hit   = valid_r[idx_r] && (ip_mem_r[idx_r] == key);
  assign first = (idx_r == '0);

  assign sts.scan_last = (idx_r == IW'(N - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign frame_ok = (req_r.frame_len >= acr_pkg::MIN_FRAME_LEN) &&
                    (req_r.hw_type == acr_pkg::HW_ETHER) &&
                    (req_r.proto_type == acr_pkg::PROTO_IPV4) &&
                    (req_r.hw_len == acr_pkg::HW_ADDR_LEN) &&
                    (req_r.proto_len == acr_pkg::PROTO_ADDR_LEN);
  assign sip_nz   = (req_r.sender_ip != 32'd0);
  assign learn_en = (req_r.mode == acr_pkg::MODE_FRAME) && frame_ok && sip_nz;
  assign slot     = match_found_r ? match_idx_r : (free_found_r ? free_idx_r : min_idx_r);

  always_comb begin
    res_nxt = '{action: acr_pkg::ACT_NONE, send_op: acr_pkg::SOP_NONE,
                mac_out: 48'd0, ip_out: 32'd0};
    case (req_r.mode)
      acr_pkg::MODE_FRAME: begin
        if (frame_ok) begin
          if (req_r.opcode == acr_pkg::OPCODE_REQUEST) begin
            if (req_r.target_ip == own_ip_r) begin
              res_nxt = '{action: acr_pkg::ACT_REPLY, send_op: acr_pkg::SOP_REPLY,
                          mac_out: req_r.sender_mac, ip_out: req_r.sender_ip};
            end
          end else if (req_r.opcode == acr_pkg::OPCODE_REPLY && sip_nz) begin
            // A nonzero sender was just learned, so it is always cached here.
            res_nxt = '{action: acr_pkg::ACT_RESOLVED, send_op: acr_pkg::SOP_NONE,
                        mac_out: req_r.sender_mac, ip_out: req_r.sender_ip};
          end
        end
      end
      acr_pkg::MODE_LOOKUP: begin
        if (match_found_r) begin
          res_nxt = '{action: acr_pkg::ACT_HIT, send_op: acr_pkg::SOP_NONE,
                      mac_out: match_mac_r, ip_out: req_r.query_ip};
        end else begin
          res_nxt = '{action: acr_pkg::ACT_MISS, send_op: acr_pkg::SOP_REQUEST,
                      mac_out: acr_pkg::MAC_BROADCAST, ip_out: req_r.query_ip};
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tick_r      <= 32'd0;
      own_ip_r    <= 32'd0;
      own_mac_r   <= 48'd0;
      for (int i = 0; i < N; i++) valid_r[i] <= 1'b0;
    end else begin
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.finish && req_r.mode == acr_pkg::MODE_TICK) tick_r <= tick_r + 32'd1;
      if (cmd.finish && learn_en) valid_r[slot] <= 1'b1;
      if (cfg_we) begin
        case (cfg_idx)
          acr_pkg::REG_OWN_IP:  own_ip_r  <= cfg_data[31:0];
          acr_pkg::REG_OWN_MAC: own_mac_r <= cfg_data[47:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      idx_r <= '0;
    end
    if (cmd.scan) begin
      idx_r <= idx_r + IW'(1);
      if (first) begin
        match_found_r <= hit;
        match_idx_r   <= idx_r;
        match_mac_r   <= mac_mem_r[idx_r];
        free_found_r  <= !valid_r[idx_r];
        free_idx_r    <= idx_r;
        min_idx_r     <= idx_r;
        min_stamp_r   <= stamp_mem_r[idx_r];
      end else begin
        if (hit && !match_found_r) begin
          match_found_r <= 1'b1;
          match_idx_r   <= idx_r;
          match_mac_r   <= mac_mem_r[idx_r];
        end
        if (!valid_r[idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= idx_r;
        end
        if (valid_r[idx_r] && stamp_mem_r[idx_r] < min_stamp_r) begin
          min_idx_r   <= idx_r;
          min_stamp_r <= stamp_mem_r[idx_r];
        end
      end
    end
    if (cmd.finish) begin
      out_r <= res_nxt;
      if (learn_en) begin
        ip_mem_r[slot]    <= req_r.sender_ip;
        mac_mem_r[slot]   <= req_r.sender_mac;
        stamp_mem_r[slot] <= tick_r;
      end
    end
  end

endmodule

@@ rtl/core/arp_cache_responder_unit.sv @@
// Top level of the ARP cache responder: controller plus datapath.
// Each request is accepted, then a sequential scan of the cache entries finds the
// matching, first free and oldest entries, and a final step updates the cache and
// loads the result register. The scan visits one entry per cycle, which sets the
// rate unless the output stalls. A finished result waits in the output register
// until taken, and the next request may enter meanwhile. The user must write own_ip
// and own_mac through the cfg port only while idle; the block does not enforce it.
module arp_cache_responder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  acr_req_if.sink                        in_req,
  acr_res_if.source                      out_res,
  input  logic                           cfg_we,
  input  acr_pkg::cfg_reg_t              cfg_idx,
  input  logic [acr_pkg::CFG_DATA_W-1:0] cfg_data
);

  acr_pkg::cmd_t cmd;
  acr_pkg::sts_t sts;

  acr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_req.data),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_data  (out_res.data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

endmodule

@@ rtl/core/acr_checker.sv @@
// Port-level checker of the ARP cache responder and its bind statement.
module acr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input acr_pkg::res_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken during cache scan");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == acr_pkg::ACT_NONE |->
      out_data.send_op == acr_pkg::SOP_NONE && out_data.mac_out == 48'd0 &&
      out_data.ip_out == 32'd0)
    else $error("empty result carries data");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == acr_pkg::ACT_MISS |->
      out_data.send_op == acr_pkg::SOP_REQUEST &&
      out_data.mac_out == acr_pkg::MAC_BROADCAST)
    else $error("miss without broadcast request");

endmodule

bind arp_cache_responder_unit acr_checker u_acr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_data  (out_res.data)
);
